@@ design/word_self_sync_scrambler_defines.svh @@
// Assertion macros shared by the scrambler checker.
`ifndef WORD_SELF_SYNC_SCRAMBLER_DEFINES_SVH
`define WORD_SELF_SYNC_SCRAMBLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/wss_pkg.sv @@
// Package: shared types and constants for the word self-synchronizing scrambler.
`default_nettype none

package wss_pkg;

  localparam int unsigned HISTORY_BITS = 32;
  localparam int unsigned WORD_BITS    = 16;
  localparam int unsigned ADDR_W       = 4;
  localparam int unsigned DATA_W       = 32;

  typedef enum logic [1:0] {
    REG_DIRECTION  = 2'd0,
    REG_BITS_WORD  = 2'd1,
    REG_FIRST_TAP  = 2'd2,
    REG_SECOND_TAP = 2'd3
  } wss_reg_t;

  typedef struct packed {
    logic       direction;
    logic [4:0] bits_per_word;
    logic [5:0] first_tap;
    logic [5:0] second_tap;
  } wss_cfg_t;

  localparam logic       DIR_SCRAMBLE   = 1'b0;
  localparam logic [4:0] BPW_RESET      = 5'd1;
  localparam logic [5:0] FIRST_RESET    = 6'd18;
  localparam logic [5:0] SECOND_RESET   = 6'd23;

endpackage

`default_nettype wire

@@ design/wss_cfg_regs.sv @@
// Configuration register file behind the APB-style port.
`default_nettype none

module wss_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [wss_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [wss_pkg::DATA_W-1:0]  pwdata,
  output logic      [wss_pkg::DATA_W-1:0]  prdata,
  output wss_pkg::wss_cfg_t                cfg,
  output logic                             cfg_wr
);

  wss_pkg::wss_cfg_t cfg_r;
  wss_pkg::wss_reg_t reg_sel;

  assign reg_sel = wss_pkg::wss_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.direction     <= wss_pkg::DIR_SCRAMBLE;
      cfg_r.bits_per_word <= wss_pkg::BPW_RESET;
      cfg_r.first_tap     <= wss_pkg::FIRST_RESET;
      cfg_r.second_tap    <= wss_pkg::SECOND_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        wss_pkg::REG_DIRECTION:  cfg_r.direction     <= pwdata[0];
        wss_pkg::REG_BITS_WORD:  cfg_r.bits_per_word <= pwdata[4:0];
        wss_pkg::REG_FIRST_TAP:  cfg_r.first_tap     <= pwdata[5:0];
        wss_pkg::REG_SECOND_TAP: cfg_r.second_tap    <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      wss_pkg::REG_DIRECTION:  prdata = {31'd0, cfg_r.direction};
      wss_pkg::REG_BITS_WORD:  prdata = {27'd0, cfg_r.bits_per_word};
      wss_pkg::REG_FIRST_TAP:  prdata = {26'd0, cfg_r.first_tap};
      wss_pkg::REG_SECOND_TAP: prdata = {26'd0, cfg_r.second_tap};
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ design/word_self_sync_scrambler.sv @@
// Top level: two-tap multi-bit self-synchronizing scrambler / descrambler.
//
// Input channel (in_valid / in_stall) carries data_word and last_in; the
// result channel (out_valid / out_stall) carries result_word and last_out.
// A transaction completes on a rising edge with valid high and stall low.
// Each input transaction yields exactly one result transaction, in order.
// Latency: the result is valid the cycle after the input is taken.
// Throughput: one word per cycle while in_stall is low; the 32-bit history is updated by one
// shift-and-XOR pass in the same cycle the word is taken.
// in_stall is raised only while the result register holds a word the
// receiver is stalling, or while reset is asserted.
// The APB-style port sets direction, bits per word and the two taps;
// any write clears the history. Write configuration only while idle.
// Reset (synchronous, rst_n low) clears the history, empties the result
// register and restores the default configuration.
`default_nettype none

module word_self_sync_scrambler (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [15:0]                 in_data_word,
  input  wire logic                        in_last_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [15:0]                 out_result_word,
  output logic                             out_last_out,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [wss_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [wss_pkg::DATA_W-1:0]  pwdata,
  output logic      [wss_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  wss_pkg::wss_cfg_t cfg;
  logic              cfg_wr;

  logic [wss_pkg::HISTORY_BITS-1:0] history_r, history_nxt;
  logic [wss_pkg::HISTORY_BITS-1:0] hist_shift, term1, term2;
  logic                             out_valid_r, out_valid_nxt;
  logic [15:0]                      result_r;
  logic                             last_r;
  logic                             in_accept;
  logic [4:0]                       nbits;
  logic [5:0]                       diff1, diff2;
  logic [16:0]                      mask_w;
  logic [15:0]                      res_word;

  wss_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  assign pready    = 1'b1;
  assign in_stall  = !rst_n || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  assign nbits = (cfg.bits_per_word > 5'd16) ? 5'd16 : cfg.bits_per_word;
  assign diff1 = cfg.first_tap - {1'b0, nbits};
  assign diff2 = cfg.second_tap - {1'b0, nbits};

  always_comb begin
    term1 = '0;
    term2 = '0;
    if ((cfg.first_tap >= {1'b0, nbits}) && !diff1[5]) begin
      term1 = history_r >> diff1[4:0];
    end
    if ((cfg.second_tap >= {1'b0, nbits}) && !diff2[5]) begin
      term2 = history_r >> diff2[4:0];
    end
  end

  assign mask_w     = (17'd1 << nbits) - 17'd1;
  assign res_word   = (term1[15:0] ^ term2[15:0] ^ in_data_word) & mask_w[15:0];
  assign hist_shift = history_r << nbits;

  always_comb begin
    history_nxt = history_r;
    if (cfg_wr) begin
      history_nxt = '0;
    end else if (in_accept) begin
      if (cfg.direction == wss_pkg::DIR_SCRAMBLE) begin
        history_nxt = hist_shift | {16'd0, res_word};
      end else begin
        history_nxt = hist_shift | {16'd0, in_data_word};
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      history_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      history_r   <= history_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      result_r <= res_word;
      last_r   <= in_last_in;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_word = result_r;
  assign out_last_out    = last_r;

endmodule

`default_nettype wire

@@ design/wss_checker.sv @@
// Port-level checker for the scrambler, bound to the top level.
`default_nettype none
`include "word_self_sync_scrambler_defines.svh"

module wss_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_last_in,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_result_word,
  input wire logic        out_last_out,
  input wire logic        pready
);

  `WSS_ASSERT_NOW(a_pready_high, clk, rst_n, 1'b1, pready, "pready dropped")
  `WSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_result_word) && $stable(out_last_out), "stalled result changed")
  `WSS_ASSERT_NEXT(a_latency, clk, rst_n, in_valid && !in_stall, out_valid && (out_last_out == $past(in_last_in)), "accepted transaction missing on output")
  `WSS_ASSERT_NOW(a_no_false_stall, clk, rst_n, !out_valid || !out_stall, !in_stall, "input stalled with room in output")

endmodule

bind word_self_sync_scrambler wss_checker u_wss_checker (.*);

`default_nettype wire
